@@ sv/discovered_server_table_top_macros.svh @@
// Assertion macros for the discovered server table.
`ifndef DISCOVERED_SERVER_TABLE_TOP_MACROS_SVH
`define DISCOVERED_SERVER_TABLE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DST_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("discovered server table check failed");

// The consequent must hold in the cycle after the antecedent.
`define DST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("discovered server table check failed");

`endif

@@ sv/dst_pkg.sv @@
// Shared types, codes and helpers of the discovered server table.
package dst_pkg;

  localparam int ENTRIES = 8;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam logic [31:0] HOLD_MS = 32'd10000;

  localparam logic [1:0] TR_UNUSED = 2'd0;
  localparam logic [1:0] TR_TCP    = 2'd1;
  localparam logic [1:0] TR_TLS    = 2'd2;

  localparam logic REQ_ANNOUNCE = 1'b0;
  localparam logic REQ_LOOKUP   = 1'b1;

  localparam logic [1:0] ST_UPDATED  = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_REPLACED = 2'd2;
  localparam logic [1:0] ST_KEPT     = 2'd3;
  localparam logic [1:0] ST_FOUND    = 2'd0;
  localparam logic [1:0] ST_NO_NAME  = 2'd1;
  localparam logic [1:0] ST_NONE     = 2'd2;

  typedef struct packed {
    logic [1:0]  transport;
    logic [63:0] key;
    logic [31:0] ip;
    logic        loopback;
    logic [15:0] port;
    logic [31:0] tstamp;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } wr_req_t;

  // True when b lies at least p ms after a, with the difference read as signed.
  function automatic logic at_least_after(logic [31:0] a, logic [31:0] b, logic [31:0] p);
    logic [31:0] d;
    d = b - a;
    return !d[31] && (d >= p);
  endfunction

endpackage

@@ sv/dst_mem.sv @@
// Entry memory with one write port, one registered read port and per-entry valid bits.
module dst_mem (
  input  logic              clk,
  input  logic              rst_n,
  input  dst_pkg::rd_req_t  rd,
  output dst_pkg::entry_t   rd_data,
  input  dst_pkg::wr_req_t  wr
);

  dst_pkg::entry_t              mem_r [dst_pkg::ENTRIES];
  logic [dst_pkg::ENTRIES-1:0]  valid_r;
  logic [dst_pkg::ENTRIES-1:0]  valid_nxt;
  dst_pkg::entry_t              rd_data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (wr.en) begin
      valid_nxt[wr.addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_data_r <= valid_r[rd.addr] ? mem_r[rd.addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/dst_ctrl.sv @@
// Request sequencer: scans the entry memory, decides, writes back on announces that are not kept and reports.
module dst_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_req_type,
  input  logic                       in_secure,
  input  logic [63:0]                in_net_key,
  input  logic [31:0]                in_ip_addr,
  input  logic                       in_ip_loopback,
  input  logic [15:0]                in_port,
  input  logic [31:0]                in_now_ms,
  output logic                       out_valid,
  output logic [1:0]                 out_status,
  output logic [31:0]                out_found_ip,
  output logic [15:0]                out_found_port,
  output logic [63:0]                out_found_key,
  output logic                       out_wanted_hit,
  output dst_pkg::rd_req_t           rd,
  input  dst_pkg::entry_t            rd_data,
  output dst_pkg::wr_req_t           wr
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  localparam logic [dst_pkg::IDX_W-1:0] LAST_IDX = dst_pkg::IDX_W'(dst_pkg::ENTRIES - 1);

  typedef struct packed {
    logic        req_type;
    logic [1:0]  tr;
    logic [63:0] key;
    logic [31:0] ip;
    logic        lb;
    logic [15:0] port;
    logic [31:0] now;
  } req_t;

  typedef struct packed {
    logic                      match_ok;
    logic [dst_pkg::IDX_W-1:0] match_idx;
    logic                      match_lb;
    logic [31:0]               match_time;
    logic                      empty_ok;
    logic [dst_pkg::IDX_W-1:0] empty_idx;
    logic                      vis;
    logic                      sel_ok;
    logic [dst_pkg::IDX_W-1:0] sel_idx;
    logic [31:0]               sel_time;
    logic [31:0]               sel_ip;
    logic [15:0]               sel_port;
    logic [63:0]               sel_key;
  } scan_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  status;
    logic [31:0] ip;
    logic [15:0] port;
    logic [63:0] key;
    logic        hit;
  } res_t;

  logic [1:0]                state_r, state_nxt;
  logic [dst_pkg::IDX_W-1:0] cnt_r, cnt_nxt;
  logic                      rv_r, rv_nxt;
  logic [dst_pkg::IDX_W-1:0] ridx_r, ridx_nxt;
  req_t                      req_r, req_nxt;
  scan_t                     scan_r, scan_nxt;
  res_t                      res_r, res_nxt;
  logic [63:0]               wanted_key_r, wanted_key_nxt;
  logic                      hit_tr;
  logic                      kept;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    req_nxt        = req_r;
    scan_nxt       = scan_r;
    res_nxt        = res_r;
    res_nxt.valid  = 1'b0;
    wanted_key_nxt = wanted_key_r;
    rv_nxt         = (state_r == S_SCAN);
    ridx_nxt       = cnt_r;
    rd.en          = 1'b0;
    rd.addr        = cnt_r;
    wr.en          = 1'b0;
    wr.addr        = scan_r.sel_idx;
    wr.data        = '{transport: req_r.tr, key: req_r.key, ip: req_r.ip,
                       loopback: req_r.lb, port: req_r.port, tstamp: req_r.now};
    hit_tr         = (rd_data.transport == req_r.tr);
    kept           = scan_r.match_ok && scan_r.match_lb && !req_r.lb &&
                     !dst_pkg::at_least_after(scan_r.match_time, req_r.now, dst_pkg::HOLD_MS);

    if (rv_r) begin
      if (req_r.req_type == dst_pkg::REQ_ANNOUNCE) begin
        if (!scan_r.match_ok && hit_tr && (rd_data.key == req_r.key)) begin
          scan_nxt.match_ok   = 1'b1;
          scan_nxt.match_idx  = ridx_r;
          scan_nxt.match_lb   = rd_data.loopback;
          scan_nxt.match_time = rd_data.tstamp;
        end
        if (!scan_r.empty_ok && (rd_data.transport == dst_pkg::TR_UNUSED)) begin
          scan_nxt.empty_ok  = 1'b1;
          scan_nxt.empty_idx = ridx_r;
        end
        if (!scan_r.sel_ok ||
            !dst_pkg::at_least_after(scan_r.sel_time, rd_data.tstamp, 32'd1)) begin
          scan_nxt.sel_ok   = 1'b1;
          scan_nxt.sel_idx  = ridx_r;
          scan_nxt.sel_time = rd_data.tstamp;
        end
      end else if (hit_tr) begin
        scan_nxt.vis = 1'b1;
        if (((req_r.key == 64'd0) || (req_r.key == rd_data.key)) &&
            (!scan_r.sel_ok ||
             dst_pkg::at_least_after(scan_r.sel_time, rd_data.tstamp, 32'd1))) begin
          scan_nxt.sel_ok   = 1'b1;
          scan_nxt.sel_idx  = ridx_r;
          scan_nxt.sel_time = rd_data.tstamp;
          scan_nxt.sel_ip   = rd_data.ip;
          scan_nxt.sel_port = rd_data.port;
          scan_nxt.sel_key  = rd_data.key;
        end
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt.req_type = in_req_type;
          req_nxt.tr       = in_secure ? dst_pkg::TR_TLS : dst_pkg::TR_TCP;
          req_nxt.key      = in_net_key;
          req_nxt.ip       = in_ip_addr;
          req_nxt.lb       = in_ip_loopback;
          req_nxt.port     = in_port;
          req_nxt.now      = in_now_ms;
          scan_nxt         = '0;
          cnt_nxt          = '0;
          state_nxt        = S_SCAN;
        end
      end
      S_SCAN: begin
        rd.en   = 1'b1;
        cnt_nxt = cnt_r + dst_pkg::IDX_W'(1);
        if (cnt_r == LAST_IDX) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        res_nxt       = '0;
        res_nxt.valid = 1'b1;
        if (req_r.req_type == dst_pkg::REQ_ANNOUNCE) begin
          if (kept) begin
            res_nxt.status = dst_pkg::ST_KEPT;
          end else begin
            wr.en       = 1'b1;
            res_nxt.hit = (req_r.key == wanted_key_r);
            if (scan_r.match_ok) begin
              wr.addr        = scan_r.match_idx;
              res_nxt.status = dst_pkg::ST_UPDATED;
            end else if (scan_r.empty_ok) begin
              wr.addr        = scan_r.empty_idx;
              res_nxt.status = dst_pkg::ST_EMPTY;
            end else begin
              wr.addr        = scan_r.sel_idx;
              res_nxt.status = dst_pkg::ST_REPLACED;
            end
          end
        end else if (scan_r.sel_ok) begin
          res_nxt.status = dst_pkg::ST_FOUND;
          res_nxt.ip     = scan_r.sel_ip;
          res_nxt.port   = scan_r.sel_port;
          res_nxt.key    = scan_r.sel_key;
          wanted_key_nxt = scan_r.sel_key;
        end else begin
          res_nxt.status = scan_r.vis ? dst_pkg::ST_NO_NAME : dst_pkg::ST_NONE;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      rv_r         <= 1'b0;
      res_r        <= '0;
      wanted_key_r <= '0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      rv_r         <= rv_nxt;
      res_r        <= res_nxt;
      wanted_key_r <= wanted_key_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ridx_r <= ridx_nxt;
    req_r  <= req_nxt;
    scan_r <= scan_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = res_r.valid;
  assign out_status     = res_r.status;
  assign out_found_ip   = res_r.ip;
  assign out_found_port = res_r.port;
  assign out_found_key  = res_r.key;
  assign out_wanted_hit = res_r.hit;

endmodule

@@ sv/discovered_server_table_top.sv @@
// Top level of the discovered server table.
//
//   channel  | ports                                  | handshake
//   request  | in_* fields                            | start high while busy low
//   result   | out_* fields                           | out_valid, one cycle
//
// out_valid rises after the scan, which reads one entry per cycle from the
// entry memory, then the registered read, the drain state and the state of
// decision and write-back, whose result is registered.
// busy is high from the cycle after acceptance until the result is issued.
// Reset is synchronous and active low and clears the entry valid bits and
// the remembered lookup key. The receiver cannot hold a result off; a new
// request may be started in the cycle in which a result is shown, so a
// request is only taken once the one before it has been fully answered.
`include "discovered_server_table_top_macros.svh"

module discovered_server_table_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_req_type,
  input  logic        in_secure,
  input  logic [63:0] in_net_key,
  input  logic [31:0] in_ip_addr,
  input  logic        in_ip_loopback,
  input  logic [15:0] in_port,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_found_ip,
  output logic [15:0] out_found_port,
  output logic [63:0] out_found_key,
  output logic        out_wanted_hit
);

  dst_pkg::rd_req_t rd;
  dst_pkg::wr_req_t wr;
  dst_pkg::entry_t  rd_data;

  dst_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd      (rd),
    .rd_data (rd_data),
    .wr      (wr)
  );

  dst_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_secure      (in_secure),
    .in_net_key     (in_net_key),
    .in_ip_addr     (in_ip_addr),
    .in_ip_loopback (in_ip_loopback),
    .in_port        (in_port),
    .in_now_ms      (in_now_ms),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_found_ip   (out_found_ip),
    .out_found_port (out_found_port),
    .out_found_key  (out_found_key),
    .out_wanted_hit (out_wanted_hit),
    .rd             (rd),
    .rd_data        (rd_data),
    .wr             (wr)
  );

  `DST_ASSERT_NEXT(a_start_busy, start && !busy, busy)
  `DST_ASSERT_SAME(a_write_busy, wr.en, busy)
  `DST_ASSERT_NEXT(a_write_result, wr.en, out_valid && !busy)
  `DST_ASSERT_SAME(a_no_read_write, wr.en, !rd.en)

endmodule
